### hdl/rtgs_pkg.sv
`default_nettype none

package rtgs_pkg;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_AMPLITUDE = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MEAN    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SPREAD  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_MEAN      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_SPREAD    = 4'd7;

    localparam int unsigned ISQRT_STEPS = 32;
    localparam int unsigned SUM_W       = 64;
    localparam int unsigned ROOT_W      = 32;
    localparam int unsigned YM_W        = 32;

    localparam int unsigned QUOT_BITS = 21;
    localparam int unsigned DIV_LANES = 2;
    localparam int unsigned MAG_W     = 33;
    localparam int unsigned SPREAD_W  = 31;
    localparam int unsigned FRAC_W    = 16;

    localparam int unsigned HORNER_K    = 8;
    localparam int unsigned T_W         = 30;
    localparam int unsigned G_W         = 31;
    localparam int unsigned RECIP_W     = 34;
    localparam int unsigned RECIP_SHIFT = 33;
    localparam int unsigned N_W         = 6;
    localparam int unsigned EXP_SIDE_W  = N_W + 1;

    localparam logic [G_W-1:0]       Q_ONE30   = 31'h4000_0000;
    localparam logic [30:0]          LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0]          LN2_Q30   = 30'd744261118;
    localparam logic [QUOT_BITS-1:0] U_CAP     = 21'h10_0000;
    localparam logic [6:0]           SHIFT_BASE  = 7'd30;
    localparam logic [6:0]           SHIFT_LIMIT = 7'd63;

    // ceil(2^33 / k), exact floor(x / k) for x < 2^30
    function automatic logic [RECIP_W-1:0] recip_m(input int unsigned k);
        logic [RECIP_W-1:0] m;
        unique case (k)
            1:       m = 34'd8589934592;
            2:       m = 34'd4294967296;
            3:       m = 34'd2863311531;
            4:       m = 34'd2147483648;
            5:       m = 34'd1717986919;
            6:       m = 34'd1431655766;
            7:       m = 34'd1227133514;
            8:       m = 34'd1073741824;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

### hdl/rtgs_isqrt.sv
`default_nettype none

module rtgs_isqrt import rtgs_pkg::*; (
    input  wire  logic              aclk,
    input  wire  logic              aresetn,
    input  wire  logic              en,
    input  wire  logic              in_vld,
    input  wire  logic [SUM_W-1:0]  value_in,
    input  wire  logic [YM_W-1:0]   side_in,
    output logic                    out_vld,
    output logic [ROOT_W-1:0]       root_out,
    output logic [YM_W-1:0]         side_out
);

    logic             vld_reg  [ISQRT_STEPS];
    logic [SUM_W-1:0] rem_reg  [ISQRT_STEPS];
    logic [SUM_W-1:0] root_reg [ISQRT_STEPS];
    logic [YM_W-1:0]  side_reg [ISQRT_STEPS];

    for (genvar i = 0; i < ISQRT_STEPS; i++) begin : g_step
        localparam logic [SUM_W-1:0] BIT_C = 64'd1 << (SUM_W - 2 - 2 * i);
        logic             src_vld;
        logic [SUM_W-1:0] src_rem;
        logic [SUM_W-1:0] src_root;
        logic [YM_W-1:0]  src_side;
        logic [SUM_W-1:0] trial;
        logic             take;

        if (i == 0) begin : g_first
            assign src_vld  = in_vld;
            assign src_rem  = value_in;
            assign src_root = '0;
            assign src_side = side_in;
        end else begin : g_next
            assign src_vld  = vld_reg[i-1];
            assign src_rem  = rem_reg[i-1];
            assign src_root = root_reg[i-1];
            assign src_side = side_reg[i-1];
        end

        assign trial = src_root + BIT_C;
        assign take  = (src_rem >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= src_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? (src_rem - trial) : src_rem;
                root_reg[i] <= take ? ((src_root >> 1) + BIT_C) : (src_root >> 1);
                side_reg[i] <= src_side;
            end
        end
    end

    assign out_vld  = vld_reg[ISQRT_STEPS-1];
    assign root_out = root_reg[ISQRT_STEPS-1][ROOT_W-1:0];
    assign side_out = side_reg[ISQRT_STEPS-1];

endmodule

`default_nettype wire

### hdl/rtgs_div2.sv
`default_nettype none

module rtgs_div2 import rtgs_pkg::*; (
    input  wire  logic                                aclk,
    input  wire  logic                                aresetn,
    input  wire  logic                                en,
    input  wire  logic                                in_vld,
    input  wire  logic [DIV_LANES-1:0][MAG_W-1:0]     mag_in,
    input  wire  logic [DIV_LANES-1:0][SPREAD_W-1:0]  spread_in,
    output logic                                      out_vld,
    output logic [DIV_LANES-1:0][QUOT_BITS-1:0]       quot_out
);

    localparam int unsigned NUM_W  = MAG_W + FRAC_W;
    localparam int unsigned DEN_W  = SPREAD_W + QUOT_BITS - 1;
    localparam int unsigned OVF_SH = QUOT_BITS - FRAC_W;
    localparam int unsigned OVF_W  = SPREAD_W + OVF_SH;

    logic vld_reg [QUOT_BITS];

    for (genvar i = 0; i < QUOT_BITS; i++) begin : g_vld
        logic src_vld;
        if (i == 0) begin : g_first
            assign src_vld = in_vld;
        end else begin : g_next
            assign src_vld = vld_reg[i-1];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= src_vld;
            end
        end
    end

    assign out_vld = vld_reg[QUOT_BITS-1];

    for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
        logic [SPREAD_W-1:0]  den;
        logic [NUM_W-1:0]     rem_reg [QUOT_BITS];
        logic [QUOT_BITS-1:0] q_reg   [QUOT_BITS];
        logic                 ovf_reg [QUOT_BITS];

        // zero spread acts as one LSB
        assign den = (spread_in[l] == '0) ? SPREAD_W'(1) : spread_in[l];

        for (genvar i = 0; i < QUOT_BITS; i++) begin : g_step
            localparam int unsigned B = QUOT_BITS - 1 - i;
            logic [NUM_W-1:0]     src_rem;
            logic [QUOT_BITS-1:0] src_q;
            logic                 src_ovf;
            logic [DEN_W-1:0]     trial;
            logic [DEN_W-1:0]     rem_ext;
            logic                 take;

            if (i == 0) begin : g_first
                assign src_rem = {mag_in[l], {FRAC_W{1'b0}}};
                assign src_q   = '0;
                assign src_ovf = (OVF_W'(mag_in[l]) >= {den, {OVF_SH{1'b0}}});
            end else begin : g_next
                assign src_rem = rem_reg[i-1];
                assign src_q   = q_reg[i-1];
                assign src_ovf = ovf_reg[i-1];
            end

            assign trial   = DEN_W'(den) << B;
            assign rem_ext = DEN_W'(src_rem);
            assign take    = (rem_ext >= trial);

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= take ? NUM_W'(rem_ext - trial) : src_rem;
                    q_reg[i]   <= src_q | (QUOT_BITS'(take) << B);
                    ovf_reg[i] <= src_ovf;
                end
            end
        end

        assign quot_out[l] = (ovf_reg[QUOT_BITS-1] || (q_reg[QUOT_BITS-1] > U_CAP)) ?
                             U_CAP : q_reg[QUOT_BITS-1];
    end

endmodule

`default_nettype wire

### hdl/rtgs_exp.sv
`default_nettype none

module rtgs_exp import rtgs_pkg::*; (
    input  wire  logic                   aclk,
    input  wire  logic                   aresetn,
    input  wire  logic                   en,
    input  wire  logic                   in_vld,
    input  wire  logic [T_W-1:0]         t_in,
    input  wire  logic [EXP_SIDE_W-1:0]  side_in,
    output logic                         out_vld,
    output logic [G_W-1:0]               g_out,
    output logic [EXP_SIDE_W-1:0]        side_out
);

    // two stages per Horner step: t*acc, then divide by k via reciprocal and subtract from one
    logic                  vld_a_reg  [HORNER_K];
    logic [T_W-1:0]        x_reg      [HORNER_K];
    logic [T_W-1:0]        t_a_reg    [HORNER_K];
    logic [EXP_SIDE_W-1:0] side_a_reg [HORNER_K];
    logic                  vld_b_reg  [HORNER_K];
    logic [G_W-1:0]        acc_reg    [HORNER_K];
    logic [T_W-1:0]        t_b_reg    [HORNER_K];
    logic [EXP_SIDE_W-1:0] side_b_reg [HORNER_K];

    for (genvar j = 0; j < HORNER_K; j++) begin : g_step
        localparam logic [RECIP_W-1:0] M_C = recip_m(HORNER_K - j);
        logic                  src_vld;
        logic [G_W-1:0]        src_acc;
        logic [T_W-1:0]        src_t;
        logic [EXP_SIDE_W-1:0] src_side;
        logic [T_W+G_W-1:0]    prod_a;
        logic [63:0]           prod_b;

        if (j == 0) begin : g_first
            assign src_vld  = in_vld;
            assign src_acc  = Q_ONE30;
            assign src_t    = t_in;
            assign src_side = side_in;
        end else begin : g_next
            assign src_vld  = vld_b_reg[j-1];
            assign src_acc  = acc_reg[j-1];
            assign src_t    = t_b_reg[j-1];
            assign src_side = side_b_reg[j-1];
        end

        assign prod_a = (T_W+G_W)'(src_t) * (T_W+G_W)'(src_acc);
        assign prod_b = 64'(x_reg[j]) * 64'(M_C);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_a_reg[j] <= 1'b0;
                vld_b_reg[j] <= 1'b0;
            end else if (en) begin
                vld_a_reg[j] <= src_vld;
                vld_b_reg[j] <= vld_a_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[j]      <= prod_a[T_W+29:30];
                t_a_reg[j]    <= src_t;
                side_a_reg[j] <= src_side;
                acc_reg[j]    <= Q_ONE30 - {1'b0, prod_b[RECIP_SHIFT+T_W-1:RECIP_SHIFT]};
                t_b_reg[j]    <= t_a_reg[j];
                side_b_reg[j] <= side_a_reg[j];
            end
        end
    end

    assign out_vld  = vld_b_reg[HORNER_K-1];
    assign g_out    = acc_reg[HORNER_K-1];
    assign side_out = side_b_reg[HORNER_K-1];

endmodule

`default_nettype wire

### hdl/radial_temporal_gaussian_source_top.sv
// Pipeline: 80 register stages from the input to m_valid, most of them in the 32-step
// square root pipeline, the 21-step divider pipeline and the 16-stage exponential pipeline.
// Throughput: one item per cycle; s_ready drops only while the output skid holds an item.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
// No clearing pass; the block accepts items in the first cycle after reset.
`default_nettype none

module radial_temporal_gaussian_source_top import rtgs_pkg::*; (
    input  wire  logic                   aclk,
    input  wire  logic                   aresetn,
    input  wire  logic                   cfg_we,
    input  wire  logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire  logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire  logic                   s_valid,
    output logic                         s_ready,
    input  wire  logic signed [31:0]     s_pos_x,
    input  wire  logic signed [31:0]     s_pos_y,
    input  wire  logic signed [31:0]     s_pos_z,
    input  wire  logic signed [31:0]     s_time_in,
    output logic                         m_valid,
    input  wire  logic                   m_ready,
    output logic signed [31:0]           m_source_value
);

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 32'(~d + 33'd1) : d[31:0];
    endfunction

    // configuration
    logic [31:0]         center_x_reg, center_y_reg, center_z_reg;
    logic [31:0]         peak_amplitude_reg, radius_mean_reg, time_mean_reg;
    logic [SPREAD_W-1:0] radius_spread_reg, time_spread_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            center_z_reg       <= '0;
            peak_amplitude_reg <= 32'd65536;
            radius_mean_reg    <= '0;
            radius_spread_reg  <= 31'd65536;
            time_mean_reg      <= '0;
            time_spread_reg    <= 31'd65536;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_X:       center_x_reg       <= cfg_data;
                REG_CENTER_Y:       center_y_reg       <= cfg_data;
                REG_CENTER_Z:       center_z_reg       <= cfg_data;
                REG_PEAK_AMPLITUDE: peak_amplitude_reg <= cfg_data;
                REG_RADIUS_MEAN:    radius_mean_reg    <= cfg_data;
                REG_RADIUS_SPREAD:  radius_spread_reg  <= cfg_data[SPREAD_W-1:0];
                REG_TIME_MEAN:      time_mean_reg      <= cfg_data;
                REG_TIME_SPREAD:    time_spread_reg    <= cfg_data[SPREAD_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic skid_vld_reg;
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    // front stages: differences, squares, saturating sum
    logic              v1_reg, v2_reg, v3_reg;
    logic [31:0]       dx_reg, dy_reg, dz_reg, ym1_reg, ym2_reg, ym3_reg;
    logic [SUM_W-1:0]  sqx_reg, sqy_reg, sqz_reg, sum_reg;
    logic [SUM_W+1:0]  sum_full;

    assign sum_full = (SUM_W+2)'(sqx_reg) + (SUM_W+2)'(sqy_reg) + (SUM_W+2)'(sqz_reg);

    // square root
    logic             sq_vld;
    logic [ROOT_W-1:0] root_dist;
    logic [YM_W-1:0]  ym_sq;

    rtgs_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (v3_reg),
        .value_in (sum_reg),
        .side_in  (ym3_reg),
        .out_vld  (sq_vld),
        .root_out (root_dist),
        .side_out (ym_sq)
    );

    logic              vx_reg;
    logic [MAG_W-1:0]  xm_reg, ym_reg;
    logic [33:0]       xdiff;

    assign xdiff = {2'b00, root_dist} - {{2{radius_mean_reg[31]}}, radius_mean_reg};

    // division by spread
    logic                                dv_vld;
    logic [DIV_LANES-1:0][MAG_W-1:0]     dv_mag;
    logic [DIV_LANES-1:0][SPREAD_W-1:0]  dv_spread;
    logic [DIV_LANES-1:0][QUOT_BITS-1:0] dv_quot;

    assign dv_mag[0]    = xm_reg;
    assign dv_mag[1]    = ym_reg;
    assign dv_spread[0] = radius_spread_reg;
    assign dv_spread[1] = time_spread_reg;

    rtgs_div2 u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_vld    (vx_reg),
        .mag_in    (dv_mag),
        .spread_in (dv_spread),
        .out_vld   (dv_vld),
        .quot_out  (dv_quot)
    );

    // exponent assembly
    logic                 vt_reg, ve_reg, vw_reg, vtt_reg;
    logic [2*QUOT_BITS-1:0] ux_sq, uy_sq;
    logic [23:0]          tx_reg, ty_reg;
    logic [24:0]          e_sum;
    logic [QUOT_BITS-1:0] e_reg;
    logic                 far_e_reg, far_w_reg, far_t_reg;
    logic [51:0]          w_prod;
    logic [N_W-1:0]       n_w_reg, n_t_reg;
    logic [FRAC_W-1:0]    f_reg;
    logic [45:0]          t_prod;
    logic [T_W-1:0]       t_reg;

    assign ux_sq  = (2*QUOT_BITS)'(dv_quot[0]) * (2*QUOT_BITS)'(dv_quot[0]);
    assign uy_sq  = (2*QUOT_BITS)'(dv_quot[1]) * (2*QUOT_BITS)'(dv_quot[1]);
    assign e_sum  = 25'(tx_reg) + 25'(ty_reg);
    assign w_prod = 52'(e_reg) * 52'(LOG2E_Q30);
    assign t_prod = 46'(f_reg) * 46'(LN2_Q30);

    // exponential
    logic                  ex_vld;
    logic [G_W-1:0]        g;
    logic [EXP_SIDE_W-1:0] ex_side;

    rtgs_exp u_exp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_vld   (vtt_reg),
        .t_in     (t_reg),
        .side_in  ({far_t_reg, n_t_reg}),
        .out_vld  (ex_vld),
        .g_out    (g),
        .side_out (ex_side)
    );

    // scale by amplitude and round
    logic           vp_reg, vr_reg;
    logic [31:0]    amp_mag;
    logic [62:0]    p_reg;
    logic [N_W-1:0] n_p_reg;
    logic           far_p_reg;
    logic [6:0]     shamt;
    logic [63:0]    rounded;
    logic           zero_res;
    logic [31:0]    res_next, res_reg;

    assign amp_mag  = peak_amplitude_reg[31] ? (~peak_amplitude_reg + 32'd1) : peak_amplitude_reg;
    assign shamt    = SHIFT_BASE + 7'(n_p_reg);
    assign rounded  = (64'(p_reg) + (64'd1 << (shamt - 7'd1))) >> shamt;
    assign zero_res = far_p_reg || (shamt >= SHIFT_LIMIT);
    assign res_next = zero_res ? 32'd0 :
                      (peak_amplitude_reg[31] ? (~rounded[31:0] + 32'd1) : rounded[31:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vx_reg  <= 1'b0;
            vt_reg  <= 1'b0;
            ve_reg  <= 1'b0;
            vw_reg  <= 1'b0;
            vtt_reg <= 1'b0;
            vp_reg  <= 1'b0;
            vr_reg  <= 1'b0;
        end else if (en) begin
            v1_reg  <= s_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vx_reg  <= sq_vld;
            vt_reg  <= dv_vld;
            ve_reg  <= vt_reg;
            vw_reg  <= ve_reg;
            vtt_reg <= vw_reg;
            vp_reg  <= ex_vld;
            vr_reg  <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg    <= abs_diff(s_pos_x, center_x_reg);
            dy_reg    <= abs_diff(s_pos_y, center_y_reg);
            dz_reg    <= abs_diff(s_pos_z, center_z_reg);
            ym1_reg   <= abs_diff(s_time_in, time_mean_reg);
            sqx_reg   <= 64'(dx_reg) * 64'(dx_reg);
            sqy_reg   <= 64'(dy_reg) * 64'(dy_reg);
            sqz_reg   <= 64'(dz_reg) * 64'(dz_reg);
            ym2_reg   <= ym1_reg;
            sum_reg   <= (sum_full[SUM_W+1:SUM_W] != 2'b00) ? '1 : sum_full[SUM_W-1:0];
            ym3_reg   <= ym2_reg;
            xm_reg    <= xdiff[33] ? MAG_W'(~xdiff + 34'd1) : xdiff[MAG_W-1:0];
            ym_reg    <= MAG_W'(ym_sq);
            tx_reg    <= ux_sq[40:17];
            ty_reg    <= uy_sq[40:17];
            e_reg     <= e_sum[QUOT_BITS-1:0];
            far_e_reg <= (e_sum[24:QUOT_BITS] != '0);
            n_w_reg   <= w_prod[51:46];
            f_reg     <= w_prod[45:30];
            far_w_reg <= far_e_reg;
            t_reg     <= t_prod[45:16];
            n_t_reg   <= n_w_reg;
            far_t_reg <= far_w_reg;
            p_reg     <= 63'(amp_mag) * 63'(g);
            n_p_reg   <= ex_side[N_W-1:0];
            far_p_reg <= ex_side[N_W];
            res_reg   <= res_next;
        end
    end

    // output register with skid
    logic        out_vld_reg;
    logic [31:0] out_data_reg, skid_data_reg;
    logic        pop, fire;

    assign pop  = out_vld_reg && m_ready;
    assign fire = en && vr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (pop) begin
                skid_vld_reg <= 1'b0;
            end
        end else if (fire) begin
            if (out_vld_reg && !m_ready) begin
                skid_vld_reg <= 1'b1;
            end else begin
                out_vld_reg <= 1'b1;
            end
        end else if (pop) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (fire) begin
            if (out_vld_reg && !m_ready) begin
                skid_data_reg <= res_reg;
            end else begin
                out_data_reg <= res_reg;
            end
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_source_value = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds an item while output is empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_ready))
        else $error("skid filled without a stalled output");

    a_far_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && vp_reg && far_p_reg) |=> (res_reg == 32'd0))
        else $error("far exponent did not give zero");

endmodule

`default_nettype wire

### sim/tb_radial_temporal_gaussian_source_top.sv
`default_nettype none

module tb_radial_temporal_gaussian_source_top;
    import rtgs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [31:0]    s_pos_x = '0;
    logic signed [31:0]    s_pos_y = '0;
    logic signed [31:0]    s_pos_z = '0;
    logic signed [31:0]    s_time_in = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic signed [31:0]    m_source_value;

    radial_temporal_gaussian_source_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z), .s_time_in(s_time_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_source_value(m_source_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the configuration registers
    logic [31:0] shadow_cfg [8];
    logic [31:0] expected_values [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_off_len = 0;
    bit          hold_off_tgl = 1'b0;
    bit          hold_off_seen = 1'b0;
    int          hold_off_cycles = 0;

    function automatic logic [63:0] abs_diff(input logic signed [63:0] a,
                                             input logic signed [63:0] b);
        logic signed [63:0] d;
        d = a - b;
        return d < 0 ? -d : d;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem = v;
        root = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= root + bitv) begin
                rem = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] half_sq_ratio(input logic [63:0] mag,
                                                  input logic [63:0] spread);
        logic [63:0] u;
        logic [63:0] sp;
        sp = (spread == 0) ? 64'd1 : spread;
        u = (mag << 16) / sp;
        if (u > 64'd1048576) u = 64'd1048576;
        return (u * u) >> 17;
    endfunction

    function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [31:0] gaussian_value(input logic signed [31:0] px,
                                                   input logic signed [31:0] py,
                                                   input logic signed [31:0] pz,
                                                   input logic signed [31:0] tm);
        logic [63:0] dx, dy, dz, sum, root_val, xm, ym, e, w, n, f, t, g, s, p, m;
        logic signed [63:0] amp;
        logic [63:0] res;
        dx = abs_diff(px, $signed(shadow_cfg[REG_CENTER_X]));
        dy = abs_diff(py, $signed(shadow_cfg[REG_CENTER_Y]));
        dz = abs_diff(pz, $signed(shadow_cfg[REG_CENTER_Z]));
        sum = sat_sum(sat_sum(dx * dx, dy * dy), dz * dz);
        root_val = int_sqrt(sum);
        xm = abs_diff($signed(root_val), $signed(shadow_cfg[REG_RADIUS_MEAN]));
        ym = abs_diff(tm, $signed(shadow_cfg[REG_TIME_MEAN]));
        e = half_sq_ratio(xm, {33'd0, shadow_cfg[REG_RADIUS_SPREAD][30:0]})
            + half_sq_ratio(ym, {33'd0, shadow_cfg[REG_TIME_SPREAD][30:0]});
        amp = $signed(shadow_cfg[REG_PEAK_AMPLITUDE]);
        res = 0;
        if (e < 64'd2097152) begin
            w = (e * 64'd1549082005) >> 30;
            n = w >> 16;
            f = w & 64'hFFFF;
            t = (f * 64'd744261118) >> 16;
            g = 64'd1073741824;
            for (int k = 8; k >= 1; k--)
                g = 64'd1073741824 - ((t * g) >> 30) / k;
            s = 30 + n;
            if (s < 63) begin
                p = (amp < 0 ? -amp : amp) * g;
                m = (p + (64'd1 << (s - 1))) >> s;
                res = amp < 0 ? -m : m;
            end
        end
        return res[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_values.size() == 0)
                report_mismatch("unexpected item", m_source_value, 32'h0);
            else if (m_source_value !== expected_values[0]) begin
                report_mismatch("source_value", m_source_value, expected_values[0]);
                void'(expected_values.pop_front());
            end else
                void'(expected_values.pop_front());
        end
    end

    // receiver stall, with an optional long hold-off
    always @(posedge aclk) begin
        if (hold_off_tgl != hold_off_seen) begin
            hold_off_seen <= hold_off_tgl;
            hold_off_cycles <= hold_off_len;
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx < 8)
            shadow_cfg[idx] = (idx == REG_RADIUS_SPREAD || idx == REG_TIME_SPREAD)
                              ? {1'b0, val[30:0]} : val;
        @(posedge aclk);
    endtask

    task automatic send_item(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz, input logic [31:0] tm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= px;
        s_pos_y <= py;
        s_pos_z <= pz;
        s_time_in <= tm;
        expected_values.push_back(gaussian_value(px, py, pz, tm));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle;
        s_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
    endfunction

    task automatic test_directed;
        logic [31:0] ext [4];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        send_item(0, 0, 0, 0);
        send_item(32'h0001_0000, 0, 0, 0);
        send_item(0, 0, 0, 32'h0001_8000);
        send_item(32'h0008_0000, 0, 0, 0);
        send_item(0, 0, 0, 32'h0010_0000);
        for (int i = 0; i < 4; i++)
            send_item(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4]);
        send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        wait_idle();
        write_reg(REG_RADIUS_SPREAD, 32'h0);
        write_reg(REG_TIME_SPREAD, 32'h8000_0000);
        send_item(0, 0, 0, 0);
        send_item(1, 0, 0, 0);
        send_item(0, 0, 0, 1);
        wait_idle();
        write_reg(REG_RADIUS_SPREAD, 32'h7FFF_FFFF);
        write_reg(REG_TIME_SPREAD, 32'h7FFF_FFFF);
        write_reg(REG_PEAK_AMPLITUDE, 32'h8000_0000);
        send_item(32'h7FFF_FFFF, 0, 0, 32'h8000_0000);
        send_item(0, 0, 0, 0);
        wait_idle();
        write_reg(REG_PEAK_AMPLITUDE, 32'h7FFF_FFFF);
        write_reg(4'd9, 32'h1234_5678);
        send_item(0, 0, 0, 0);
        send_item(32'h0000_4000, 32'h0000_4000, 0, 32'hFFFF_C000);
        wait_idle();
    endtask

    task automatic random_config(input bit extreme);
        for (int r = 0; r < 8; r++) begin
            logic [31:0] v;
            case (r)
                REG_PEAK_AMPLITUDE: v = extreme ? ($urandom_range(1) ? 32'h7FFF_FFFF
                                                  : 32'h8000_0000) : $urandom;
                REG_RADIUS_SPREAD, REG_TIME_SPREAD:
                    v = extreme ? ($urandom_range(1) ? 32'h1 : 32'hFFFF_FFFF)
                                : $urandom_range(32'h0000_1000, 32'h0040_0000);
                REG_RADIUS_MEAN: v = $urandom_range(0, 32'h0040_0000);
                default: v = extreme ? $urandom : rand_coord();
            endcase
            write_reg(r[CFG_IDX_W-1:0], v);
        end
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++)
            send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        wait_idle();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_len = 300;
        hold_off_tgl = ~hold_off_tgl;
        for (int i = 0; i < 120; i++)
            send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < 8; i++) shadow_cfg[i] = 0;
        shadow_cfg[REG_PEAK_AMPLITUDE] = 32'h0001_0000;
        shadow_cfg[REG_RADIUS_SPREAD] = 32'h0001_0000;
        shadow_cfg[REG_TIME_SPREAD] = 32'h0001_0000;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        random_config(1'b0);
        test_random(150, 27, 79);
        random_config(1'b1);
        test_random(80, 79, 27);
        random_config(1'b0);
        test_random(150, 0, 0);
        test_backpressure();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
